### src/sfbt_pkg.sv
// Shared types and constants for the size-ordered free block table.
package sfbt_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int ADDR_BITS_DEF = 32;
  localparam int SIZE_W        = 32;
  localparam int FIELD_W       = 32;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_BEST_FIT = 2'd2,
    OP_LARGEST  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  // Per-cycle commands from the sequencer to every cell of the row.
  typedef struct packed {
    logic scan_en;
    logic apply_en;
  } ctrl_t;

endpackage

### src/sfbt_cell.sv
// One table cell: holds an entry, takes part in the scan chain and shifts with its neighbors.
module sfbt_cell import sfbt_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctrl_t                ctrl,
  input  op_t                  cmd_op,
  input  logic [ADDR_BITS-1:0] cmd_addr,
  input  logic [SIZE_W-1:0]    cmd_size,
  input  logic                 prev_valid,
  input  logic [ADDR_BITS-1:0] prev_addr,
  input  logic [SIZE_W-1:0]    prev_size,
  input  logic                 prev_gt,
  input  logic                 next_valid,
  input  logic [ADDR_BITS-1:0] next_addr,
  input  logic [SIZE_W-1:0]    next_size,
  input  logic                 scan_in_found,
  input  logic [ADDR_BITS-1:0] scan_in_addr,
  input  logic [SIZE_W-1:0]    scan_in_size,
  output logic                 valid,
  output logic [ADDR_BITS-1:0] addr,
  output logic [SIZE_W-1:0]    size,
  output logic                 gt,
  output logic                 scan_out_found,
  output logic [ADDR_BITS-1:0] scan_out_addr,
  output logic [SIZE_W-1:0]    scan_out_size
);

  logic                 valid_r, valid_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic                 scan_found_r;
  logic [ADDR_BITS-1:0] scan_addr_r;
  logic [SIZE_W-1:0]    scan_size_r;
  logic                 del_r;
  logic                 hit;
  logic                 take;

  // An empty cell counts as larger than anything, so the insert point is
  // the first cell that is empty or holds a strictly larger size.
  assign gt = !valid_r || (size_r > cmd_size);

  always_comb begin
    unique case (cmd_op)
      OP_INSERT:   hit = 1'b0;
      OP_REMOVE:   hit = valid_r && (addr_r == cmd_addr);
      OP_BEST_FIT: hit = valid_r && (size_r >= cmd_size);
      OP_LARGEST:  hit = valid_r;
    endcase
  end

  // The largest query keeps the last valid entry; the others keep the first hit.
  assign take = hit && ((cmd_op == OP_LARGEST) || !scan_in_found);

  always_comb begin
    valid_nxt = valid_r;
    addr_nxt  = addr_r;
    size_nxt  = size_r;
    if (ctrl.apply_en) begin
      unique case (cmd_op)
        OP_INSERT: begin
          if (gt && !prev_gt) begin
            valid_nxt = 1'b1;
            addr_nxt  = cmd_addr;
            size_nxt  = cmd_size;
          end else if (gt) begin
            valid_nxt = prev_valid;
            addr_nxt  = prev_addr;
            size_nxt  = prev_size;
          end
        end
        OP_REMOVE: begin
          if (del_r) begin
            valid_nxt = next_valid;
            addr_nxt  = next_addr;
            size_nxt  = next_size;
          end
        end
        OP_BEST_FIT, OP_LARGEST: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      scan_found_r <= 1'b0;
      del_r        <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (ctrl.scan_en) begin
        scan_found_r <= scan_in_found || hit;
        del_r        <= scan_in_found || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    size_r <= size_nxt;
    if (ctrl.scan_en) begin
      scan_addr_r <= take ? addr_r : scan_in_addr;
      scan_size_r <= take ? size_r : scan_in_size;
    end
  end

  assign valid          = valid_r;
  assign addr           = addr_r;
  assign size           = size_r;
  assign scan_out_found = scan_found_r;
  assign scan_out_addr  = scan_addr_r;
  assign scan_out_size  = scan_size_r;

endmodule

### src/sorted_free_block_table.sv
// Top level of the size-ordered free block table: sequencer, command registers and cell row.
//
// The table holds up to DEPTH free blocks (address, size) in ascending size
// order, one block per cell of a row of identical cells. A command item is
// taken at a rising edge where start is high and busy is low; its fields are
// in_operation, in_block_address and in_block_size. Every item gives exactly
// one result item, shown on out_status, out_found_address and out_found_size
// for a single cycle while out_valid is high. The receiver cannot stall, so
// the result is simply taken at the edge that ends that cycle.
// After an item is accepted, a scan token walks the row through the cells' scan
// registers, one cell per cycle, until it has passed the last cell; an apply
// state then shifts the entries for an insert or remove and registers the result.
// Busy is high through the scan and apply states and is low again while the
// result shows, so a new item is accepted at the edge that ends the result
// cycle at the earliest; no item is taken while one is in flight. The length
// of the scan row sets how long the scan lasts.
// Reset clears the valid bit of every cell, leaving an empty table; the
// entry data are not cleared and are never read while their cell is empty.
module sorted_free_block_table import sfbt_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [FIELD_W-1:0] in_block_address,
  input  logic [SIZE_W-1:0]  in_block_size,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_found_address,
  output logic [SIZE_W-1:0]  out_found_size
);

  localparam int CNT_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     cnt_r;
  op_t                  op_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [SIZE_W-1:0]    size_r;
  logic                 out_valid_r;
  status_t              status_r;
  logic [FIELD_W-1:0]   found_addr_r;
  logic [SIZE_W-1:0]    found_size_r;

  logic                 accept;
  logic                 full;
  ctrl_t                ctrl;
  logic [ADDR_BITS-1:0] in_addr_fit;
  logic [FIELD_W-1:0]   scan_addr_out;

  // Per-cell views of the row; the prev_ and next_ arrays carry each
  // cell's neighbors, with constants at the two ends of the row.
  logic                 cell_valid [DEPTH];
  logic [ADDR_BITS-1:0] cell_addr  [DEPTH];
  logic [SIZE_W-1:0]    cell_size  [DEPTH];
  logic                 cell_gt    [DEPTH];
  logic                 prev_valid [DEPTH];
  logic [ADDR_BITS-1:0] prev_addr  [DEPTH];
  logic [SIZE_W-1:0]    prev_size  [DEPTH];
  logic                 prev_gt    [DEPTH];
  logic                 next_valid [DEPTH];
  logic [ADDR_BITS-1:0] next_addr  [DEPTH];
  logic [SIZE_W-1:0]    next_size  [DEPTH];
  logic                 scan_found [DEPTH];
  logic [ADDR_BITS-1:0] scan_addr  [DEPTH];
  logic [SIZE_W-1:0]    scan_size  [DEPTH];
  logic                 sin_found  [DEPTH];
  logic [ADDR_BITS-1:0] sin_addr   [DEPTH];
  logic [SIZE_W-1:0]    sin_size   [DEPTH];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // The table is full when the last cell holds an entry; an insert then
  // leaves the row untouched and reports the drop.
  assign full = cell_valid[DEPTH-1];

  assign ctrl.scan_en  = (state_r == ST_SCAN);
  assign ctrl.apply_en = (state_r == ST_APPLY) && !((op_r == OP_INSERT) && full);

  // Stored addresses are kept to ADDR_BITS bits, and results return
  // them zero-extended or cut to the 32-bit port.
  generate
    if (ADDR_BITS > FIELD_W) begin : g_wide_addr
      assign in_addr_fit   = {{(ADDR_BITS-FIELD_W){1'b0}}, in_block_address};
      assign scan_addr_out = scan_addr[DEPTH-1][FIELD_W-1:0];
    end else if (ADDR_BITS == FIELD_W) begin : g_same_addr
      assign in_addr_fit   = in_block_address;
      assign scan_addr_out = scan_addr[DEPTH-1];
    end else begin : g_narrow_addr
      assign in_addr_fit   = in_block_address[ADDR_BITS-1:0];
      assign scan_addr_out = {{(FIELD_W-ADDR_BITS){1'b0}}, scan_addr[DEPTH-1]};
    end
  endgenerate

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
        // The head of the row has no left neighbor; the scan token
        // enters here empty.
        assign prev_valid[g] = 1'b0;
        assign prev_addr[g]  = '0;
        assign prev_size[g]  = '0;
        assign prev_gt[g]    = 1'b0;
        assign sin_found[g]  = 1'b0;
        assign sin_addr[g]   = '0;
        assign sin_size[g]   = '0;
      end else begin : g_body
        assign prev_valid[g] = cell_valid[g-1];
        assign prev_addr[g]  = cell_addr[g-1];
        assign prev_size[g]  = cell_size[g-1];
        assign prev_gt[g]    = cell_gt[g-1];
        assign sin_found[g]  = scan_found[g-1];
        assign sin_addr[g]   = scan_addr[g-1];
        assign sin_size[g]   = scan_size[g-1];
      end

      if (g == DEPTH-1) begin : g_tail
        // A remove shifts an empty slot into the tail cell.
        assign next_valid[g] = 1'b0;
        assign next_addr[g]  = '0;
        assign next_size[g]  = '0;
      end else begin : g_inner
        assign next_valid[g] = cell_valid[g+1];
        assign next_addr[g]  = cell_addr[g+1];
        assign next_size[g]  = cell_size[g+1];
      end

      sfbt_cell #(
        .ADDR_BITS(ADDR_BITS)
      ) u_cell (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cmd_op         (op_r),
        .cmd_addr       (addr_r),
        .cmd_size       (size_r),
        .prev_valid     (prev_valid[g]),
        .prev_addr      (prev_addr[g]),
        .prev_size      (prev_size[g]),
        .prev_gt        (prev_gt[g]),
        .next_valid     (next_valid[g]),
        .next_addr      (next_addr[g]),
        .next_size      (next_size[g]),
        .scan_in_found  (sin_found[g]),
        .scan_in_addr   (sin_addr[g]),
        .scan_in_size   (sin_size[g]),
        .valid          (cell_valid[g]),
        .addr           (cell_addr[g]),
        .size           (cell_size[g]),
        .gt             (cell_gt[g]),
        .scan_out_found (scan_found[g]),
        .scan_out_addr  (scan_addr[g]),
        .scan_out_size  (scan_size[g])
      );
    end
  endgenerate

  // Command registers hold the accepted item for the whole operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_operation);
      addr_r <= in_addr_fit;
      size_r <= in_block_size;
    end
  end

  // Sequencer: scan the row, then an apply state shifts entries and
  // registers the result, which is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_SCAN;
            cnt_r   <= '0;
          end
        end
        ST_SCAN: begin
          if (cnt_r == CNT_W'(DEPTH-1)) begin
            state_r <= ST_APPLY;
          end
          cnt_r <= cnt_r + 1'b1;
        end
        ST_APPLY: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload, captured in the apply cycle from the end of the scan row.
  always_ff @(posedge clk) begin
    if (state_r == ST_APPLY) begin
      found_addr_r <= '0;
      found_size_r <= '0;
      unique case (op_r)
        OP_INSERT: begin
          status_r <= full ? STAT_FULL : STAT_OK;
        end
        OP_REMOVE: begin
          status_r <= scan_found[DEPTH-1] ? STAT_OK : STAT_MISS;
        end
        OP_BEST_FIT, OP_LARGEST: begin
          if (scan_found[DEPTH-1]) begin
            status_r     <= STAT_OK;
            found_addr_r <= scan_addr_out;
            found_size_r <= scan_size[DEPTH-1];
          end else begin
            status_r <= STAT_MISS;
          end
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found_address = found_addr_r;
  assign out_found_size    = found_size_r;

endmodule
